// ===== src/drt_pkg.sv =====
// Shared types, codes and constants for the divider and reloading timer.
// No dependencies; imported by drt_datapath and divider_and_reloading_timer.
`timescale 1ns / 1ps

package drt_pkg;

  localparam int unsigned DivStepCycles = 64;
  localparam logic [7:0]  CtrlReset     = 8'hF8;
  localparam int unsigned CtrlEnableBit = 2;
  localparam logic [7:0]  CountMax      = 8'hFF;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_READ  = 2'd1,
    OP_WRITE = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    REG_DIV = 2'd0,
    REG_CNT = 2'd1,
    REG_RLD = 2'd2,
    REG_CTL = 2'd3
  } reg_sel_t;

  typedef enum logic [0:0] {
    ST_IDLE = 1'b0,
    ST_RUN  = 1'b1
  } state_t;

  typedef struct packed {
    logic       start_tick;
    logic       wr_en;
    logic       step_en;
    reg_sel_t   sel;
    logic [7:0] wdata;
    logic [5:0] cycles;
  } dp_ctrl_t;

  typedef struct packed {
    logic       done;
    logic       irq;
    logic [7:0] rd_data;
  } dp_status_t;

  function automatic logic [8:0] period_of(input logic [1:0] code);
    logic [8:0] p;
    case (code)
      2'd0:    p = 9'd256;
      2'd1:    p = 9'd4;
      2'd2:    p = 9'd16;
      default: p = 9'd64;
    endcase
    return p;
  endfunction

endpackage

// ===== src/drt_datapath.sv =====
// Timer register file and the shared subtract/compare unit for the period loop.
// Depends on drt_pkg for control and status structs and the period table.
`timescale 1ns / 1ps

module drt_datapath (
  input  logic                clk,
  input  logic                rst_n,
  input  drt_pkg::dp_ctrl_t   ctrl,
  output drt_pkg::dp_status_t status
);
  import drt_pkg::*;

  logic [7:0] div_r,    div_nxt;
  logic [5:0] div_acc_r, div_acc_nxt;
  logic [7:0] cnt_r,    cnt_nxt;
  logic [7:0] rld_r,    rld_nxt;
  logic [7:0] ctl_r,    ctl_nxt;
  logic [8:0] tacc_r,   tacc_nxt;
  logic       irq_r,    irq_nxt;

  logic [6:0] div_sum;
  logic [8:0] period;
  logic [9:0] diff;
  logic       enable;
  logic       ge;

  assign div_sum = {1'b0, div_acc_r} + {1'b0, ctrl.cycles};
  assign enable  = ctl_r[CtrlEnableBit];
  assign period  = period_of(ctl_r[1:0]);
  // shared unit: accumulator against period
  assign diff    = {1'b0, tacc_r} - {1'b0, period};
  assign ge      = ~diff[9];

  always_comb begin
    div_nxt     = div_r;
    div_acc_nxt = div_acc_r;
    cnt_nxt     = cnt_r;
    rld_nxt     = rld_r;
    ctl_nxt     = ctl_r;
    tacc_nxt    = tacc_r;
    irq_nxt     = irq_r;
    if (ctrl.start_tick) begin
      irq_nxt = 1'b0;
      div_acc_nxt = div_sum[5:0];
      if (div_sum >= 7'(DivStepCycles)) begin
        div_nxt = div_r + 8'd1;
      end
      if (enable) begin
        tacc_nxt = tacc_r + {3'b000, ctrl.cycles};
      end
    end else if (ctrl.wr_en) begin
      case (ctrl.sel)
        REG_DIV: div_nxt = '0;
        REG_CNT: cnt_nxt = ctrl.wdata;
        REG_RLD: rld_nxt = ctrl.wdata;
        REG_CTL: ctl_nxt = ctrl.wdata;
        default: ctl_nxt = ctl_r;
      endcase
    end else if (ctrl.step_en && enable && ge) begin
      tacc_nxt = diff[8:0];
      if (cnt_r == CountMax) begin
        cnt_nxt = rld_r;
        irq_nxt = 1'b1;
      end else begin
        cnt_nxt = cnt_r + 8'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_r     <= '0;
      div_acc_r <= '0;
      cnt_r     <= '0;
      rld_r     <= '0;
      ctl_r     <= CtrlReset;
      tacc_r    <= '0;
      irq_r     <= 1'b0;
    end else begin
      div_r     <= div_nxt;
      div_acc_r <= div_acc_nxt;
      cnt_r     <= cnt_nxt;
      rld_r     <= rld_nxt;
      ctl_r     <= ctl_nxt;
      tacc_r    <= tacc_nxt;
      irq_r     <= irq_nxt;
    end
  end

  always_comb begin
    status.done = ~enable | ~ge;
    status.irq  = irq_r;
    case (ctrl.sel)
      REG_DIV: status.rd_data = div_r;
      REG_CNT: status.rd_data = cnt_r;
      REG_RLD: status.rd_data = rld_r;
      REG_CTL: status.rd_data = ctl_r;
      default: status.rd_data = '0;
    endcase
  end

endmodule

// ===== src/divider_and_reloading_timer.sv =====
// Top level of the divider and reloading timer: stream ports, sequencer, output register.
// Depends on drt_pkg and drt_datapath.
`timescale 1ns / 1ps

// Every input transaction yields exactly one result transaction. Reads and writes
// complete in the accepting cycle and their result appears on the next cycle. A tick
// drains N timer periods from the timer accumulator (at most 79, when a long period is
// cut to 4); the drain loop runs one period subtraction per cycle through the single
// subtract/compare unit. The block is not ready while a tick drains or while the output
// register holds an untaken result.
module divider_and_reloading_timer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,  // write_value[7:0], elapsed_cycles[13:8], zero pad
  input  logic [3:0]  in_tuser,  // operation[1:0], reg_select[3:2]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata, // read_value[7:0]
  output logic [0:0]  out_tuser  // timer_irq[0]
);
  import drt_pkg::*;

  state_t     state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic [7:0] out_data_r;
  logic       out_irq_r;

  dp_ctrl_t   ctrl;
  dp_status_t status;

  logic       accept;
  logic       out_free;
  logic       load_out;
  logic [7:0] load_data;
  logic       load_irq;
  op_t        op;

  assign op       = op_t'(in_tuser[1:0]);
  assign out_free = ~out_valid_r | out_tready;
  assign accept   = in_tvalid & in_tready;

  drt_datapath u_dp (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctrl   (ctrl),
    .status (status)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept && op == OP_TICK) state_nxt = ST_RUN;
      end
      ST_RUN: begin
        if (status.done && out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_tready       = 1'b0;
    load_out        = 1'b0;
    load_data       = '0;
    load_irq        = 1'b0;
    ctrl.start_tick = 1'b0;
    ctrl.wr_en      = 1'b0;
    ctrl.step_en    = 1'b0;
    ctrl.sel        = reg_sel_t'(in_tuser[3:2]);
    ctrl.wdata      = in_tdata[7:0];
    ctrl.cycles     = in_tdata[13:8];
    case (state_r)
      ST_IDLE: begin
        in_tready = out_free;
        if (accept) begin
          case (op)
            OP_TICK:  ctrl.start_tick = 1'b1;
            OP_READ: begin
              load_out  = 1'b1;
              load_data = status.rd_data;
            end
            OP_WRITE: begin
              load_out   = 1'b1;
              ctrl.wr_en = 1'b1;
            end
            default:  load_out = 1'b1;
          endcase
        end
      end
      ST_RUN: begin
        ctrl.step_en = 1'b1;
        if (status.done && out_free) begin
          load_out = 1'b1;
          load_irq = status.irq;
        end
      end
      default: in_tready = 1'b0;
    endcase
  end

  assign out_valid_nxt = load_out | (out_valid_r & ~out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_data_r <= load_data;
      out_irq_r  <= load_irq;
    end
  end

  assign out_tvalid   = out_valid_r;
  assign out_tdata    = out_data_r;
  assign out_tuser[0] = out_irq_r;

  a_no_accept_while_running : assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_RUN |-> !in_tready)
    else $error("input taken while a tick drains");

  a_ready_needs_free_output : assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> (!out_tvalid || out_tready))
    else $error("input taken with a stalled result pending");

  a_tick_starts_run : assert property (@(posedge clk) disable iff (!rst_n)
    (accept && op == OP_TICK) |=> state_r == ST_RUN)
    else $error("tick did not start the drain loop");

  a_run_end_gives_result : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RUN && status.done && out_free) |=> (out_tvalid && state_r == ST_IDLE))
    else $error("finished tick produced no result");

endmodule
